[rtl/core/pbw_pkg.sv]
`default_nettype none

package pbw_pkg;

    // Result kinds
    localparam logic [2:0] KIND_SCALAR  = 3'd0;
    localparam logic [2:0] KIND_LENGTH  = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD = 3'd2;
    localparam logic [2:0] KIND_MSG_OK  = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    // Wire types that the decoder understands
    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LENGTH  = 3'd2;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    // Varint byte fields
    localparam logic [7:0] VARINT_DATA_MASK = 8'h7F;
    localparam int         VARINT_CONT_BIT  = 7;
    localparam logic [3:0] VARINT_LAST_IDX  = 4'd9;

    // Result queue depth; two slots must be free to take a byte
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        PH_TAG     = 6'b000001,
        PH_VARINT  = 6'b000010,
        PH_FIXED   = 6'b000100,
        PH_LENGTH  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DROP    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] value;
        logic        payload_end;
        logic        last_result;
    } t_result;

    // Results produced by one byte, first in order
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

`default_nettype wire

[rtl/core/protobuf_wire_parser.sv]
`default_nettype none

// Streaming protobuf wire-format decoder, one message byte per transfer.
// A byte is registered on input and decoded from that register; its
// results are written into a four-entry result queue, from which they
// leave in order, read straight from its memory. The block takes
// one byte per cycle as long as the consumer takes one result per cycle. A
// byte yields zero, one or two results (two when the message's last byte
// also yields a field, length or payload result, which is then followed by
// message ok or error); the queue must have two free entries
// for the registered byte to be decoded, which sets the rate when results
// pile up. Each result carries last_result on the final result of its byte.
// After an error all bytes up to the end of the message are dropped.
module protobuf_wire_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_field_number,
    output logic [2:0]       o_wire_type,
    output logic [63:0]      o_value,
    output logic             o_payload_end,
    output logic             o_last_result
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eom;
    logic             space;
    logic             consume;
    pbw_pkg::t_push   push;
    pbw_pkg::t_result result;

    assign consume    = r_in_valid && space;
    assign o_in_stall = r_in_valid && !space;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
            r_in_eom  <= i_end_of_message;
        end
    end

    pbw_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (consume),
        .i_in_byte        (r_in_byte),
        .i_end_of_message (r_in_eom),
        .o_push           (push)
    );

    pbw_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (result)
    );

    assign o_kind         = result.kind;
    assign o_field_number = result.field_number;
    assign o_wire_type    = result.wire_type;
    assign o_value        = result.value;
    assign o_payload_end  = result.payload_end;
    assign o_last_result  = result.last_result;

    // Results enter the queue only when it has room for them
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num != 2'd0) |-> space)
        else $error("result push without queue space");

    // A single result closes its byte
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num == 2'd1) |-> push.first.last_result)
        else $error("single result lacks last mark");

    // Two results: only the second is marked last, and it closes the message
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num == 2'd2) |-> (!push.first.last_result && push.second.last_result
            && (push.second.kind == pbw_pkg::KIND_MSG_OK
                || push.second.kind == pbw_pkg::KIND_ERROR)))
        else $error("result pair marked wrongly");

    // Two results come only from the last byte of a message
    a_pair_eom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num == 2'd2) |-> r_in_eom)
        else $error("two results without end of message");

endmodule

`default_nettype wire

[rtl/core/pbw_decode.sv]
`default_nettype none

module pbw_decode (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_go,
    input  wire logic [7:0]     i_in_byte,
    input  wire logic           i_end_of_message,
    output pbw_pkg::t_push      o_push
);

    pbw_pkg::t_phase r_phase, n_phase;
    logic [63:0]     r_acc, n_acc;
    logic [3:0]      r_shift, n_shift;
    logic [31:0]     r_field, n_field;
    logic [2:0]      r_wire, n_wire;
    logic [63:0]     r_remain, n_remain;

    pbw_pkg::t_result res_main, res_eom, res_first;
    logic             main_vld, eom_vld;
    logic [6:0]       var_shamt;
    logic [5:0]       fix_shamt;
    logic [63:0]      vint;

    // Per-byte state update and result build
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_shift   = r_shift;
        n_field   = r_field;
        n_wire    = r_wire;
        n_remain  = r_remain;
        res_main  = '0;
        res_eom   = '0;
        main_vld  = 1'b0;
        eom_vld   = 1'b0;
        vint      = '0;
        var_shamt = ({3'b000, r_shift} << 3) - {3'b000, r_shift};
        fix_shamt = {r_shift[2:0], 3'b000};

        case (r_phase)
            pbw_pkg::PH_TAG, pbw_pkg::PH_VARINT, pbw_pkg::PH_LENGTH: begin
                n_acc = r_acc | (64'(i_in_byte & pbw_pkg::VARINT_DATA_MASK) << var_shamt);
                if (i_in_byte[pbw_pkg::VARINT_CONT_BIT]) begin
                    if (r_shift >= pbw_pkg::VARINT_LAST_IDX) begin
                        // Overlong varint: flag and drop the rest of the message
                        main_vld               = 1'b1;
                        res_main.kind          = pbw_pkg::KIND_ERROR;
                        res_main.field_number  = r_field;
                        res_main.wire_type     = r_wire;
                        n_phase  = pbw_pkg::PH_DROP;
                        n_acc    = '0;
                        n_shift  = '0;
                        n_field  = '0;
                        n_wire   = '0;
                        n_remain = '0;
                    end else begin
                        n_shift = r_shift + 4'd1;
                    end
                end else begin
                    vint    = n_acc;
                    n_acc   = '0;
                    n_shift = '0;
                    if (r_phase == pbw_pkg::PH_TAG) begin
                        n_field = vint[34:3];
                        n_wire  = vint[2:0];
                        case (vint[2:0])
                            pbw_pkg::WIRE_VARINT:  n_phase = pbw_pkg::PH_VARINT;
                            pbw_pkg::WIRE_FIXED64: begin
                                n_phase  = pbw_pkg::PH_FIXED;
                                n_remain = 64'd8;
                            end
                            pbw_pkg::WIRE_FIXED32: begin
                                n_phase  = pbw_pkg::PH_FIXED;
                                n_remain = 64'd4;
                            end
                            pbw_pkg::WIRE_LENGTH:  n_phase = pbw_pkg::PH_LENGTH;
                            default: begin
                                // Unsupported wire type
                                main_vld              = 1'b1;
                                res_main.kind         = pbw_pkg::KIND_ERROR;
                                res_main.field_number = vint[34:3];
                                res_main.wire_type    = vint[2:0];
                                n_phase = pbw_pkg::PH_DROP;
                                n_field = '0;
                                n_wire  = '0;
                            end
                        endcase
                    end else if (r_phase == pbw_pkg::PH_VARINT) begin
                        main_vld              = 1'b1;
                        res_main.kind         = pbw_pkg::KIND_SCALAR;
                        res_main.field_number = r_field;
                        res_main.wire_type    = r_wire;
                        res_main.value        = vint;
                        n_phase = pbw_pkg::PH_TAG;
                        n_field = '0;
                        n_wire  = '0;
                    end else begin
                        main_vld              = 1'b1;
                        res_main.kind         = pbw_pkg::KIND_LENGTH;
                        res_main.field_number = r_field;
                        res_main.wire_type    = r_wire;
                        res_main.value        = vint;
                        if (vint == 64'd0) begin
                            n_phase = pbw_pkg::PH_TAG;
                            n_field = '0;
                            n_wire  = '0;
                        end else begin
                            n_remain = vint;
                            n_phase  = pbw_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            pbw_pkg::PH_FIXED: begin
                n_acc   = r_acc | (64'(i_in_byte) << fix_shamt);
                n_shift = {1'b0, r_shift[2:0]} + 4'd1;
                if (r_remain != 64'd0) begin
                    n_remain = r_remain - 64'd1;
                end
                if (n_remain == 64'd0) begin
                    main_vld              = 1'b1;
                    res_main.kind         = pbw_pkg::KIND_SCALAR;
                    res_main.field_number = r_field;
                    res_main.wire_type    = r_wire;
                    res_main.value        = n_acc;
                    n_phase = pbw_pkg::PH_TAG;
                    n_acc   = '0;
                    n_shift = '0;
                    n_field = '0;
                    n_wire  = '0;
                end
            end
            pbw_pkg::PH_PAYLOAD: begin
                if (r_remain != 64'd0) begin
                    n_remain = r_remain - 64'd1;
                end
                main_vld              = 1'b1;
                res_main.kind         = pbw_pkg::KIND_PAYLOAD;
                res_main.field_number = r_field;
                res_main.wire_type    = r_wire;
                res_main.value        = 64'(i_in_byte);
                res_main.payload_end  = (n_remain == 64'd0);
                if (n_remain == 64'd0) begin
                    n_phase = pbw_pkg::PH_TAG;
                    n_acc   = '0;
                    n_shift = '0;
                    n_field = '0;
                    n_wire  = '0;
                end
            end
            default: begin
                // Dropping: ignore the byte
            end
        endcase

        // Close the message on its last byte
        if (i_end_of_message) begin
            if (n_phase == pbw_pkg::PH_TAG && n_shift == 4'd0) begin
                eom_vld      = 1'b1;
                res_eom.kind = pbw_pkg::KIND_MSG_OK;
            end else if (n_phase != pbw_pkg::PH_DROP) begin
                eom_vld              = 1'b1;
                res_eom.kind         = pbw_pkg::KIND_ERROR;
                res_eom.field_number = n_field;
                res_eom.wire_type    = n_wire;
            end
            n_phase  = pbw_pkg::PH_TAG;
            n_acc    = '0;
            n_shift  = '0;
            n_field  = '0;
            n_wire   = '0;
            n_remain = '0;
        end
    end

    // Order the results and mark the last one
    always_comb begin
        res_first             = main_vld ? res_main : res_eom;
        res_first.last_result = !(main_vld && eom_vld);
        o_push.first          = res_first;
        o_push.second         = res_eom;
        o_push.second.last_result = 1'b1;
        o_push.num            = i_go ? (2'(main_vld) + 2'(eom_vld)) : 2'd0;
    end

    // Hold state between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pbw_pkg::PH_TAG;
            r_acc    <= '0;
            r_shift  <= '0;
            r_field  <= '0;
            r_wire   <= '0;
            r_remain <= '0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_shift  <= n_shift;
            r_field  <= n_field;
            r_wire   <= n_wire;
            r_remain <= n_remain;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pbw_result_queue.sv]
`default_nettype none

module pbw_result_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pbw_pkg::t_push    i_push,
    output logic                   o_space,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output pbw_pkg::t_result       o_result
);

    pbw_pkg::t_result r_mem [pbw_pkg::QUEUE_DEPTH];

    logic [pbw_pkg::QUEUE_PTR_W-1:0] r_wr, n_wr, r_rd, n_rd, wr_next;
    logic [pbw_pkg::QUEUE_CNT_W-1:0] r_count, n_count;
    logic                            pop;

    // Room for the worst case of two results per byte
    assign o_space  = (r_count <= pbw_pkg::QUEUE_CNT_W'(pbw_pkg::QUEUE_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && !i_stall;
    assign wr_next  = r_wr + pbw_pkg::QUEUE_PTR_W'(1);

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = r_wr + pbw_pkg::QUEUE_PTR_W'(i_push.num);
        n_rd    = pop ? r_rd + pbw_pkg::QUEUE_PTR_W'(1) : r_rd;
        n_count = r_count + pbw_pkg::QUEUE_CNT_W'(i_push.num)
                - pbw_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store results of this byte
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

endmodule

`default_nettype wire

[test/tb_protobuf_wire_parser.sv]
module tb_protobuf_wire_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import pbw_pkg::*;

    // Wire types the decoder rejects, and the wire type reported before a tag is complete
    localparam logic [2:0] WIRE_NONE        = 3'd0;
    localparam logic [2:0] WIRE_START_GROUP = 3'd3;
    localparam logic [2:0] WIRE_END_GROUP   = 3'd4;
    localparam logic [2:0] WIRE_RESERVED_6  = 3'd6;
    localparam logic [2:0] WIRE_RESERVED_7  = 3'd7;

    localparam int RANDOM_ITEMS = 1600;
    localparam int IDLE_PCT     = 24;
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 1000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int PAUSE_AT     = 1200;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
        logic       has_fixed;
        t_result    fixed_result;
    } t_stim;

    localparam t_result NO_RESULT = '0;

    // Directed bytes; rows with has_fixed set carry their single result typed in
    localparam int N_DIRECTED = 28;
    localparam t_stim DIRECTED [N_DIRECTED] = '{
        // start-group wire type right after reset, then drop to end of message
        '{8'h0B, 1'b0, 1'b1, '{KIND_ERROR, 32'd1, WIRE_START_GROUP, 64'd0, 1'b0, 1'b1}},
        '{8'hAA, 1'b1, 1'b0, NO_RESULT},
        // remaining unsupported wire types, each closing its message
        '{8'h0C, 1'b1, 1'b1, '{KIND_ERROR, 32'd1, WIRE_END_GROUP, 64'd0, 1'b0, 1'b1}},
        '{8'h0E, 1'b1, 1'b1, '{KIND_ERROR, 32'd1, WIRE_RESERVED_6, 64'd0, 1'b0, 1'b1}},
        '{8'h0F, 1'b1, 1'b1, '{KIND_ERROR, 32'd1, WIRE_RESERVED_7, 64'd0, 1'b0, 1'b1}},
        // zero-length field then message ok
        '{8'h12, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        // two payload bytes, the last closing the message
        '{8'h12, 1'b0, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b0, NO_RESULT},
        // fixed32 of all ones
        '{8'h0D, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b0, NO_RESULT},
        // message ends after the length, before its payload
        '{8'h12, 1'b0, 1'b0, NO_RESULT},
        '{8'h05, 1'b1, 1'b0, NO_RESULT},
        // overlong tag varint
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, '{KIND_ERROR, 32'd0, WIRE_NONE, 64'd0, 1'b0, 1'b1}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte = '0;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [31:0] o_field_number;
    logic [2:0]  o_wire_type;
    logic [63:0] o_value;
    logic        o_payload_end;
    logic        o_last_result;

    protobuf_wire_parser DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_byte        (i_in_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_field_number   (o_field_number),
        .o_wire_type      (o_wire_type),
        .o_value          (o_value),
        .o_payload_end    (o_payload_end),
        .o_last_result    (o_last_result)
    );

    always #1 i_clk = ~i_clk;

    t_stim      byte_stream[$];
    logic [7:0] msg_bytes[$];
    t_result    byte_results[$];
    t_result    predicted_results[$];
    int         mismatches = 0;
    int         bytes_taken = 0;
    bit         calm = 1'b0;

    // Decoder state mirrored by the predictor
    t_phase      dec_phase;
    logic [63:0] dec_acc;
    logic [63:0] dec_left;
    logic [3:0]  dec_shift;
    logic [31:0] dec_field;
    logic [2:0]  dec_wire;

    function automatic t_result make_result(input logic [2:0] kind, input logic [31:0] field,
                                            input logic [2:0] wt, input logic [63:0] value,
                                            input logic pend);
        t_result r;
        r.kind         = kind;
        r.field_number = field;
        r.wire_type    = wt;
        r.value        = value;
        r.payload_end  = pend;
        r.last_result  = 1'b0;
        return r;
    endfunction

    function automatic string show_result(input t_result r);
        return $sformatf("kind=%0d field=%0d wire=%0d value=%h pend=%b last=%b",
                         r.kind, r.field_number, r.wire_type, r.value, r.payload_end,
                         r.last_result);
    endfunction

    task automatic restart_field();
        dec_phase = PH_TAG;
        dec_acc   = '0;
        dec_shift = '0;
        dec_field = '0;
        dec_wire  = '0;
        dec_left  = '0;
    endtask

    task automatic raise_decode_error();
        byte_results.push_back(make_result(KIND_ERROR, dec_field, dec_wire, '0, 1'b0));
        restart_field();
        dec_phase = PH_DROP;
    endtask

    // Predict the results of one message byte
    task automatic decode_byte(input logic [7:0] b, input logic eom);
        int unsigned sc;
        logic [63:0] v;
        byte_results.delete();
        case (dec_phase)
            PH_TAG, PH_VARINT, PH_LENGTH: begin
                sc = dec_shift % 10;
                dec_acc |= 64'(b & VARINT_DATA_MASK) << (7 * sc);
                if (b[VARINT_CONT_BIT]) begin
                    if (sc >= VARINT_LAST_IDX) raise_decode_error();
                    else dec_shift = 4'(sc + 1);
                end else begin
                    v = dec_acc;
                    dec_acc = '0;
                    dec_shift = '0;
                    if (dec_phase == PH_TAG) begin
                        dec_field = v[34:3];
                        dec_wire  = v[2:0];
                        case (dec_wire)
                            WIRE_VARINT: dec_phase = PH_VARINT;
                            WIRE_FIXED64: begin
                                dec_phase = PH_FIXED;
                                dec_left  = 64'd8;
                            end
                            WIRE_FIXED32: begin
                                dec_phase = PH_FIXED;
                                dec_left  = 64'd4;
                            end
                            WIRE_LENGTH: dec_phase = PH_LENGTH;
                            default: raise_decode_error();
                        endcase
                    end else if (dec_phase == PH_VARINT) begin
                        byte_results.push_back(make_result(KIND_SCALAR, dec_field, dec_wire,
                                                           v, 1'b0));
                        restart_field();
                    end else begin
                        byte_results.push_back(make_result(KIND_LENGTH, dec_field, dec_wire,
                                                           v, 1'b0));
                        if (v == 0) begin
                            restart_field();
                        end else begin
                            dec_left  = v;
                            dec_phase = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_FIXED: begin
                sc = dec_shift[2:0];
                dec_acc |= 64'(b) << (8 * sc);
                dec_shift = 4'(sc + 1);
                if (dec_left > 0) dec_left--;
                if (dec_left == 0) begin
                    byte_results.push_back(make_result(KIND_SCALAR, dec_field, dec_wire,
                                                       dec_acc, 1'b0));
                    restart_field();
                end
            end
            PH_PAYLOAD: begin
                if (dec_left > 0) dec_left--;
                byte_results.push_back(make_result(KIND_PAYLOAD, dec_field, dec_wire,
                                                   64'(b), dec_left == 0));
                if (dec_left == 0) restart_field();
            end
            default: ;
        endcase

        // Close the message: ok on a field boundary, error inside a field, nothing while dropping
        if (eom) begin
            if (dec_phase == PH_TAG && dec_shift == 0)
                byte_results.push_back(make_result(KIND_MSG_OK, '0, WIRE_NONE, '0, 1'b0));
            else if (dec_phase != PH_DROP)
                byte_results.push_back(make_result(KIND_ERROR, dec_field, dec_wire, '0, 1'b0));
            restart_field();
        end

        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last_result = 1'b1;
    endtask

    task automatic accept_byte(input t_stim s);
        decode_byte(s.data, s.eom);
        if (s.has_fixed) predicted_results.push_back(s.fixed_result);
        else foreach (byte_results[k]) predicted_results.push_back(byte_results[k]);
    endtask

    // Encode a varint; loose encodings pad with redundant bytes and junk above bit 63
    task automatic put_varint(input logic [63:0] v, input bit loose);
        int nb;
        logic [7:0] bv;
        nb = 1;
        while (nb < 10 && (v >> (7 * nb)) != 0) nb++;
        if (loose) nb = $urandom_range(10, nb);
        for (int i = 0; i < nb; i++) begin
            bv = {1'b0, 7'(v >> (7 * i))};
            bv[VARINT_CONT_BIT] = (i != nb - 1);
            if (loose && i == 9) bv[6:1] = 6'($urandom);
            msg_bytes.push_back(bv);
        end
    endtask

    task automatic put_field();
        logic [63:0] tag;
        logic [63:0] v;
        logic [2:0]  wt;
        int          r;
        int          len;
        r = $urandom_range(0, 99);
        if (r < 30) wt = WIRE_VARINT;
        else if (r < 45) wt = WIRE_FIXED64;
        else if (r < 60) wt = WIRE_FIXED32;
        else if (r < 93) wt = WIRE_LENGTH;
        else begin
            case ($urandom_range(0, 3))
                0: wt = WIRE_START_GROUP;
                1: wt = WIRE_END_GROUP;
                2: wt = WIRE_RESERVED_6;
                default: wt = WIRE_RESERVED_7;
            endcase
        end

        // Mostly small field numbers, some full 32-bit, some wider than 32 bits
        r = $urandom_range(0, 99);
        if (r < 70) tag = 64'($urandom_range(1, 15)) << 3;
        else if (r < 90) tag = 64'($urandom) << 3;
        else tag = {$urandom, $urandom};
        tag[2:0] = wt;
        put_varint(tag, $urandom_range(0, 9) == 0);

        case (wt)
            WIRE_VARINT: begin
                r = $urandom_range(0, 9);
                if (r == 0) v = '1;
                else if (r == 1) v = '0;
                else v = {$urandom, $urandom} >> $urandom_range(0, 63);
                put_varint(v, $urandom_range(0, 9) == 0);
            end
            WIRE_FIXED64: repeat (8) msg_bytes.push_back(8'($urandom));
            WIRE_FIXED32: repeat (4) msg_bytes.push_back(8'($urandom));
            WIRE_LENGTH: begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
                put_varint(64'(len), $urandom_range(0, 9) == 0);
                repeat (len) msg_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    // Mostly well-formed messages; some truncated, some with an overlong tag, some noise
    task automatic put_message();
        int    r;
        int    cut;
        t_stim s;
        msg_bytes.delete();
        r = $urandom_range(0, 99);
        if (r >= 95) begin
            repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom));
        end else begin
            if (r >= 90) repeat (10) msg_bytes.push_back({1'b1, 7'($urandom)});
            repeat ($urandom_range(1, 4)) put_field();
            if (r >= 80 && r < 90 && msg_bytes.size() > 1) begin
                cut = $urandom_range(1, msg_bytes.size() - 1);
                while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
            end
        end
        foreach (msg_bytes[k]) begin
            s.data         = msg_bytes[k];
            s.eom          = (k == msg_bytes.size() - 1);
            s.has_fixed    = 1'b0;
            s.fixed_result = NO_RESULT;
            byte_stream.push_back(s);
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got = '{o_kind, o_field_number, o_wire_type, o_value, o_payload_end, o_last_result};
        if (predicted_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result with nothing awaited: %s", $time, show_result(got));
        end else begin
            want = predicted_results.pop_front();
            if (got.kind !== want.kind || got.field_number !== want.field_number ||
                got.wire_type !== want.wire_type || got.value !== want.value ||
                got.payload_end !== want.payload_end ||
                got.last_result !== want.last_result) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result mismatch", $time);
                    $display("    expected %s", show_result(want));
                    $display("    actual   %s", show_result(got));
                end
            end
        end
    endtask

    // Result side: check each transfer, stall at random, one long hold-off
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) check_result();
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!held && bytes_taken >= HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Byte side: build the stream, reset, drive, drain, report
    initial begin : byte_source
        int idx;
        bit paused;
        idx = 0;
        paused = 1'b0;
        restart_field();
        for (int i = 0; i < N_DIRECTED; i++) byte_stream.push_back(DIRECTED[i]);
        while (byte_stream.size() < N_DIRECTED + RANDOM_ITEMS) put_message();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (idx < byte_stream.size()) begin
            @(posedge i_clk);
            if (i_in_valid && !o_in_stall) begin
                accept_byte(byte_stream[idx]);
                idx++;
                bytes_taken = idx;
            end
            calm = (idx >= CALM_FIRST && idx < CALM_LAST);
            // Hold a stalled byte; otherwise offer the next one, idle, or pause
            if (!(i_in_valid && o_in_stall)) begin
                if (idx == PAUSE_AT && !paused) begin
                    paused = 1'b1;
                    i_in_valid <= 1'b0;
                    while (predicted_results.size() != 0) @(posedge i_clk);
                end else if (idx < byte_stream.size() &&
                             (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_in_byte        <= byte_stream[idx].data;
                    i_end_of_message <= byte_stream[idx].eom;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end

        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && predicted_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Give up if the run hangs
    initial begin : watchdog
        #400_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[protobuf_wire_parser.f]
rtl/core/pbw_pkg.sv
rtl/core/pbw_decode.sv
rtl/core/pbw_result_queue.sv
rtl/core/protobuf_wire_parser.sv
test/tb_protobuf_wire_parser.sv
